### rtl/sync_frame_parser_fletcher8_assert.svh
// Assertion macros shared by the parser modules.
// Each check is clocked on the rising edge and is off while reset is asserted.
`ifndef SYNC_FRAME_PARSER_FLETCHER8_ASSERT_SVH
`define SYNC_FRAME_PARSER_FLETCHER8_ASSERT_SVH

`ifndef ASSERT_OFF

`define SFP8_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define SFP8_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SFP8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFP8_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define SFP8_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define SFP8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/sfpf8_pkg.sv
`default_nettype none

package sfpf8_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_A_CODE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_A_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_B_CODE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_B_LENGTH = 3'd5;

    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_KIND_A = 2'd1;
    localparam logic [1:0] STATUS_KIND_B = 2'd2;

    localparam logic KIND_A = 1'b0;
    localparam logic KIND_B = 1'b1;

    // One received byte together with its comparisons against the configuration.
    typedef struct packed {
        logic [7:0] data;
        logic       sync_first_hit;
        logic       sync_second_hit;
        logic       type_known;
        logic       type_kind;
    } entry_t;

endpackage

`default_nettype wire

### rtl/sfpf8_queue.sv
`default_nettype none

`include "sync_frame_parser_fletcher8_assert.svh"

module sfpf8_queue #(
    parameter int DEPTH = sfpf8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  sfpf8_pkg::entry_t   push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output sfpf8_pkg::entry_t   pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfpf8_pkg::entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic push;
    logic pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SFP8_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

### rtl/sfpf8_front.sv
`default_nettype none

module sfpf8_front (
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [7:0]          rx_byte,
    input  wire  [7:0]          sync_first,
    input  wire  [7:0]          sync_second,
    input  wire  [7:0]          type_a_code,
    input  wire  [7:0]          type_b_code,
    output logic                push_valid,
    input  wire                 push_ready,
    output sfpf8_pkg::entry_t   push_data
);

    logic hit_a;
    logic hit_b;

    assign hit_a = (rx_byte == type_a_code);
    assign hit_b = (rx_byte == type_b_code);

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // Kind A takes precedence when both type codes match.
    always_comb
    begin
        push_data.data            = rx_byte;
        push_data.sync_first_hit  = (rx_byte == sync_first);
        push_data.sync_second_hit = (rx_byte == sync_second);
        push_data.type_known      = hit_a || hit_b;
        push_data.type_kind       = hit_a ? sfpf8_pkg::KIND_A : sfpf8_pkg::KIND_B;
    end

endmodule

`default_nettype wire

### rtl/sfpf8_back.sv
`default_nettype none

`include "sync_frame_parser_fletcher8_assert.svh"

module sfpf8_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    output logic                q_ready,
    input  sfpf8_pkg::entry_t   q_data,
    input  wire  [7:0]          type_a_length,
    input  wire  [7:0]          type_b_length,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [1:0]          frame_status,
    output logic                body_valid,
    output logic [7:0]          body_offset,
    output logic [7:0]          body_byte
);

    typedef enum logic [5:0] {
        ST_HUNT1 = 6'b000001,
        ST_HUNT2 = 6'b000010,
        ST_TYPE  = 6'b000100,
        ST_BODY  = 6'b001000,
        ST_CHK1  = 6'b010000,
        ST_CHK2  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       kind_reg, kind_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] frame_status_reg, frame_status_next;
    logic       body_valid_reg, body_valid_next;
    logic [7:0] body_offset_reg, body_offset_next;
    logic [7:0] body_byte_reg, body_byte_next;

    logic       pop;
    logic [7:0] sum_a_add;
    logic [7:0] type_len;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign q_ready   = pop;
    assign sum_a_add = sum_a_reg + q_data.data;
    assign type_len  = (q_data.type_kind == sfpf8_pkg::KIND_B) ? type_b_length : type_a_length;

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        len_next          = len_reg;
        cnt_next          = cnt_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        frame_status_next = sfpf8_pkg::STATUS_NONE;
        body_valid_next   = 1'b0;
        body_offset_next  = '0;
        body_byte_next    = '0;

        if (pop)
        begin
            unique case (state_reg)
                ST_HUNT1:
                begin
                    state_next = q_data.sync_first_hit ? ST_HUNT2 : ST_HUNT1;
                end
                ST_HUNT2:
                begin
                    // A mismatch here is not retried as a first sync byte.
                    state_next = q_data.sync_second_hit ? ST_TYPE : ST_HUNT1;
                end
                ST_TYPE:
                begin
                    if (q_data.type_known)
                    begin
                        kind_next       = q_data.type_kind;
                        len_next        = type_len;
                        sum_a_next      = q_data.data;
                        sum_b_next      = q_data.data;
                        cnt_next        = 8'd1;
                        body_valid_next = 1'b1;
                        body_byte_next  = q_data.data;
                        state_next      = (type_len == '0) ? ST_CHK1 : ST_BODY;
                    end
                    else
                    begin
                        state_next = ST_HUNT1;
                    end
                end
                ST_BODY:
                begin
                    sum_a_next       = sum_a_add;
                    sum_b_next       = sum_b_reg + sum_a_add;
                    body_valid_next  = 1'b1;
                    body_offset_next = cnt_reg;
                    body_byte_next   = q_data.data;
                    if (cnt_reg == len_reg)
                    begin
                        state_next = ST_CHK1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_CHK1:
                begin
                    state_next = (q_data.data == sum_a_reg) ? ST_CHK2 : ST_HUNT1;
                end
                ST_CHK2:
                begin
                    state_next = ST_HUNT1;
                    if (q_data.data == sum_b_reg)
                    begin
                        frame_status_next = (kind_reg == sfpf8_pkg::KIND_B) ?
                                            sfpf8_pkg::STATUS_KIND_B :
                                            sfpf8_pkg::STATUS_KIND_A;
                    end
                end
                default:
                begin
                    state_next = ST_HUNT1;
                end
            endcase
        end
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        len_reg   <= len_next;
        cnt_reg   <= cnt_next;
        sum_a_reg <= sum_a_next;
        sum_b_reg <= sum_b_next;
        if (pop)
        begin
            frame_status_reg <= frame_status_next;
            body_valid_reg   <= body_valid_next;
            body_offset_reg  <= body_offset_next;
            body_byte_reg    <= body_byte_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = frame_status_reg;
    assign body_valid   = body_valid_reg;
    assign body_offset  = body_offset_reg;
    assign body_byte    = body_byte_reg;

    `SFP8_ASSERT_IMPLIES(a_status_not_body, clk, rst_n, out_valid_reg && (frame_status_reg != sfpf8_pkg::STATUS_NONE), !body_valid_reg, "frame status reported on a body item")
    `SFP8_ASSERT_IMPLIES(a_body_count, clk, rst_n, state_reg == ST_BODY, (cnt_reg != '0) && (cnt_reg <= len_reg), "body counter out of range")
    `SFP8_ASSERT_NEXT(a_body_exit, clk, rst_n, pop && (state_reg == ST_BODY), (state_reg == ST_BODY) || (state_reg == ST_CHK1), "body must run into the first check byte")

endmodule

`default_nettype wire

### rtl/sync_frame_parser_fletcher8.sv
// Sync-header frame parser with a running Fletcher-8 check.
// Path: an accepted byte is held in a queue entry and its result then in the output
// register, from which it can be taken.
// Throughput: one byte per cycle unless out_ready back-pressure stalls the output register.
// Reset: configuration registers clear to zero, the parser returns to sync hunting,
// and the queue and output register empty.
`default_nettype none

module sync_frame_parser_fletcher8 #(
    parameter int QUEUE_DEPTH = sfpf8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [7:0]                          rx_byte,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [1:0]                          frame_status,
    output logic                                body_valid,
    output logic [7:0]                          body_offset,
    output logic [7:0]                          body_byte,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [sfpf8_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [7:0]                          cfg_data
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [7:0] type_a_code_reg;
    logic [7:0] type_a_length_reg;
    logic [7:0] type_b_code_reg;
    logic [7:0] type_b_length_reg;

    logic              push_valid;
    logic              push_ready;
    sfpf8_pkg::entry_t push_data;
    logic              q_valid;
    logic              q_ready;
    sfpf8_pkg::entry_t q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg    <= '0;
            sync_second_reg   <= '0;
            type_a_code_reg   <= '0;
            type_a_length_reg <= '0;
            type_b_code_reg   <= '0;
            type_b_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfpf8_pkg::REG_SYNC_FIRST:    sync_first_reg    <= cfg_data;
                sfpf8_pkg::REG_SYNC_SECOND:   sync_second_reg   <= cfg_data;
                sfpf8_pkg::REG_TYPE_A_CODE:   type_a_code_reg   <= cfg_data;
                sfpf8_pkg::REG_TYPE_A_LENGTH: type_a_length_reg <= cfg_data;
                sfpf8_pkg::REG_TYPE_B_CODE:   type_b_code_reg   <= cfg_data;
                sfpf8_pkg::REG_TYPE_B_LENGTH: type_b_length_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sfpf8_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .type_a_code (type_a_code_reg),
        .type_b_code (type_b_code_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    sfpf8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    sfpf8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_data),
        .type_a_length (type_a_length_reg),
        .type_b_length (type_b_length_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_status  (frame_status),
        .body_valid    (body_valid),
        .body_offset   (body_offset),
        .body_byte     (body_byte)
    );

endmodule

`default_nettype wire

### verif/sync_frame_parser_fletcher8_tb.sv
module sync_frame_parser_fletcher8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_ITEMS    = 230;

    localparam logic [sfpf8_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO =
        sfpf8_pkg::REG_TYPE_B_LENGTH + 1'b1;
    localparam logic [sfpf8_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = '1;

    localparam logic [8:0] POS_HUNT  = 9'd0;
    localparam logic [8:0] POS_SYNC2 = 9'd1;
    localparam logic [8:0] POS_TYPE  = 9'd2;
    localparam logic [8:0] POS_BODY  = 9'd3;

    typedef struct packed {
        logic [1:0] status;
        logic       body_valid;
        logic [7:0] body_offset;
        logic [7:0] body_byte;
    } parse_out_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECK_A,
        FLAW_CHECK_B,
        FLAW_TYPE,
        FLAW_SYNC
    } flaw_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [7:0]                        rx_byte = 8'd0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [1:0]                        frame_status;
    logic                              body_valid;
    logic [7:0]                        body_offset;
    logic [7:0]                        body_byte;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [sfpf8_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]                        cfg_data = 8'd0;

    // Handshakes seen at the last rising edge, read by the falling-edge processes.
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic cfg_fire = 1'b0;

    // Parser shadow: configuration and frame state.
    logic [7:0] cfg_sync_lead = 8'd0;
    logic [7:0] cfg_sync_follow = 8'd0;
    logic [7:0] cfg_code_a = 8'd0;
    logic [7:0] cfg_len_a = 8'd0;
    logic [7:0] cfg_code_b = 8'd0;
    logic [7:0] cfg_len_b = 8'd0;
    logic [8:0] frame_pos = POS_HUNT;
    logic       frame_kind = sfpf8_pkg::KIND_A;
    logic [7:0] frame_len = 8'd0;
    logic [7:0] fsum_lo = 8'd0;
    logic [7:0] fsum_hi = 8'd0;

    parse_out_t  parse_results_due[$];
    logic [7:0]  rx_backlog[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned failures = 0;
    int unsigned quiet_cycles = 0;
    int          send_gap_max = 16;
    int          recv_gap_max = 16;
    int          send_wait = 0;
    int          recv_wait = 0;
    int          hold_left = 0;
    int          hold_requests = 0;
    int          holds_seen = 0;

    sync_frame_parser_fletcher8 u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .body_valid   (body_valid),
        .body_offset  (body_offset),
        .body_byte    (body_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_failure(input string msg);
        failures++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic apply_register(input logic [sfpf8_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [7:0] val);
        case (idx)
            sfpf8_pkg::REG_SYNC_FIRST:    cfg_sync_lead = val;
            sfpf8_pkg::REG_SYNC_SECOND:   cfg_sync_follow = val;
            sfpf8_pkg::REG_TYPE_A_CODE:   cfg_code_a = val;
            sfpf8_pkg::REG_TYPE_A_LENGTH: cfg_len_a = val;
            sfpf8_pkg::REG_TYPE_B_CODE:   cfg_code_b = val;
            sfpf8_pkg::REG_TYPE_B_LENGTH: cfg_len_b = val;
            default: ;
        endcase
    endtask

    // One parser step on a received byte; updates the shadow frame state.
    function automatic parse_out_t parse_byte(input logic [7:0] b);
        parse_out_t r;
        logic [8:0] check_pos;
        logic [8:0] offs;
        r = '{sfpf8_pkg::STATUS_NONE, 1'b0, 8'd0, 8'd0};
        check_pos = {1'b0, frame_len} + POS_BODY;
        offs = frame_pos - POS_TYPE;
        if (frame_pos == POS_HUNT)
        begin
            frame_pos = (b == cfg_sync_lead) ? POS_SYNC2 : POS_HUNT;
        end
        else if (frame_pos == POS_SYNC2)
        begin
            frame_pos = (b == cfg_sync_follow) ? POS_TYPE : POS_HUNT;
        end
        else if (frame_pos == POS_TYPE)
        begin
            // Kind A takes precedence when both codes are equal.
            if (b == cfg_code_a || b == cfg_code_b)
            begin
                frame_kind = (b == cfg_code_a) ? sfpf8_pkg::KIND_A : sfpf8_pkg::KIND_B;
                frame_len = (b == cfg_code_a) ? cfg_len_a : cfg_len_b;
                fsum_lo = b;
                fsum_hi = b;
                frame_pos = POS_BODY;
                r.body_valid = 1'b1;
                r.body_byte = b;
            end
            else
            begin
                frame_pos = POS_HUNT;
            end
        end
        else if (frame_pos < check_pos)
        begin
            fsum_lo = fsum_lo + b;
            fsum_hi = fsum_hi + fsum_lo;
            r.body_valid = 1'b1;
            r.body_offset = offs[7:0];
            r.body_byte = b;
            frame_pos = frame_pos + 9'd1;
        end
        else if (frame_pos == check_pos)
        begin
            frame_pos = (b == fsum_lo) ? frame_pos + 9'd1 : POS_HUNT;
        end
        else
        begin
            frame_pos = POS_HUNT;
            if (b == fsum_hi)
                r.status = (frame_kind == sfpf8_pkg::KIND_B) ? sfpf8_pkg::STATUS_KIND_B :
                                                               sfpf8_pkg::STATUS_KIND_A;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        parse_out_t got;
        parse_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{frame_status, body_valid, body_offset, body_byte};
                if (parse_results_due.size() == 0)
                begin
                    note_failure("result item arrived with nothing expected");
                end
                else
                begin
                    want = parse_results_due.pop_front();
                    if (got.status != want.status)
                        note_failure($sformatf("frame_status got %0d expected %0d",
                                               got.status, want.status));
                    if (got.body_valid != want.body_valid)
                        note_failure($sformatf("body_valid got %0d expected %0d",
                                               got.body_valid, want.body_valid));
                    if (got.body_offset != want.body_offset)
                        note_failure($sformatf("body_offset got %0d expected %0d",
                                               got.body_offset, want.body_offset));
                    if (got.body_byte != want.body_byte)
                        note_failure($sformatf("body_byte got 0x%02h expected 0x%02h",
                                               got.body_byte, want.body_byte));
                end
            end
            if (in_valid && in_ready)
            begin
                parse_results_due.push_back(parse_byte(rx_byte));
                bytes_accepted++;
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sync_frame_parser_fletcher8: mismatch");
                $finish;
            end
        end
        in_fire <= in_valid && in_ready;
        out_fire <= out_valid && out_ready;
        cfg_fire <= cfg_valid && cfg_ready;
    end

    always @(negedge clk)
    begin : sender
        if (in_fire || !in_valid)
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                in_valid <= 1'b0;
            end
            else if (rx_backlog.size() > 0)
            begin
                rx_byte <= rx_backlog.pop_front();
                in_valid <= 1'b1;
                send_wait = $urandom_range(0, send_gap_max);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_fire)
                recv_wait = $urandom_range(0, recv_gap_max);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [sfpf8_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_parser(input logic [7:0] s1, input logic [7:0] s2,
                                  input logic [7:0] ca, input logic [7:0] la,
                                  input logic [7:0] cb, input logic [7:0] lb);
        // A write to an unused index must leave every register alone.
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
        write_reg(sfpf8_pkg::REG_SYNC_FIRST, s1);
        write_reg(sfpf8_pkg::REG_SYNC_SECOND, s2);
        write_reg(sfpf8_pkg::REG_TYPE_A_CODE, ca);
        write_reg(sfpf8_pkg::REG_TYPE_A_LENGTH, la);
        write_reg(sfpf8_pkg::REG_TYPE_B_CODE, cb);
        write_reg(sfpf8_pkg::REG_TYPE_B_LENGTH, lb);
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    // Queues one frame for the current configuration, optionally broken in one place.
    // A negative fill gives random body bytes.
    task automatic queue_frame(input logic as_b, input flaw_t flaw, input int fill);
        logic [7:0] code;
        logic [7:0] len;
        logic [7:0] sa;
        logic [7:0] sb;
        logic [7:0] v;
        int n;
        if (as_b && cfg_code_b != cfg_code_a)
        begin
            code = cfg_code_b;
            len = cfg_len_b;
        end
        else
        begin
            code = cfg_code_a;
            len = cfg_len_a;
        end
        push_byte(cfg_sync_lead);
        if (flaw == FLAW_SYNC)
        begin
            do v = 8'($urandom); while (v == cfg_sync_follow);
            push_byte(v);
            return;
        end
        push_byte(cfg_sync_follow);
        if (flaw == FLAW_TYPE)
        begin
            do v = 8'($urandom); while (v == cfg_code_a || v == cfg_code_b);
            push_byte(v);
            return;
        end
        push_byte(code);
        sa = code;
        sb = code;
        for (n = 0; n < len; n++)
        begin
            v = (fill < 0) ? 8'($urandom) : 8'(fill);
            sa = sa + v;
            sb = sb + sa;
            push_byte(v);
        end
        push_byte((flaw == FLAW_CHECK_A) ? ~sa : sa);
        if (flaw != FLAW_CHECK_A)
            push_byte((flaw == FLAW_CHECK_B) ? ~sb : sb);
    endtask

    task automatic queue_random_chunk();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            queue_frame(1'($urandom_range(0, 1)), FLAW_NONE, -1);
        else if (pick < 72)
            queue_frame(1'($urandom_range(0, 1)), FLAW_CHECK_A, -1);
        else if (pick < 79)
            queue_frame(1'($urandom_range(0, 1)), FLAW_CHECK_B, -1);
        else if (pick < 85)
            queue_frame(1'($urandom_range(0, 1)), FLAW_TYPE, -1);
        else if (pick < 90)
            queue_frame(1'($urandom_range(0, 1)), FLAW_SYNC, -1);
        else
            for (n = $urandom_range(1, 8); n > 0; n--)
                push_byte(8'($urandom));
    endtask

    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || parse_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int unsigned start;
        logic [7:0] s1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_parser(8'hA5, 8'h5A, 8'hFF, 8'd1, 8'h00, 8'd0);
        queue_frame(1'b0, FLAW_NONE, 8'hFF);
        queue_frame(1'b1, FLAW_NONE, -1);
        queue_frame(1'b1, FLAW_CHECK_A, -1);
        queue_frame(1'b1, FLAW_CHECK_B, -1);
        queue_frame(1'b0, FLAW_TYPE, -1);
        // The byte that breaks the sync pair is not taken as a new first sync byte.
        push_byte(8'hA5);
        push_byte(8'hA5);
        push_byte(8'h5A);
        wait_drained();

        for (phase = 0; phase < 8; phase++)
        begin
            s1 = 8'($urandom);
            case (phase)
                0: program_parser(8'h00, 8'hFF, 8'h00, 8'd0, 8'hFF, 8'd254);
                1: program_parser(8'hFF, 8'h00, 8'h33, 8'd255, 8'h33, 8'd5);
                4: program_parser(s1, s1, 8'($urandom), 8'($urandom_range(0, 6)),
                                  8'($urandom), 8'($urandom_range(0, 6)));
                5: program_parser(s1, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 255)),
                                  8'($urandom), 8'($urandom_range(0, 6)));
                default: program_parser(s1, 8'($urandom), 8'($urandom),
                                        8'($urandom_range(0, 6)),
                                        8'($urandom), 8'($urandom_range(0, 6)));
            endcase
            send_gap_max = (phase % 3 == 2) ? 0 : 16;
            recv_gap_max = (phase % 4 == 1) ? 0 : 16;
            // Long receiver hold while the sender keeps offering back to back.
            if (phase == 3 || phase == 6)
            begin
                send_gap_max = 0;
                hold_requests++;
            end
            start = bytes_queued;
            if (phase == 0)
                queue_frame(1'b1, FLAW_NONE, -1);
            if (phase == 1)
                queue_frame(1'b0, FLAW_NONE, -1);
            while (bytes_queued - start < PHASE_ITEMS)
                queue_random_chunk();
            wait_drained();
        end

        if (parse_results_due.size() != 0)
            note_failure("expected result items never arrived");
        if (failures == 0)
            $display("sync_frame_parser_fletcher8: match");
        else
            $display("sync_frame_parser_fletcher8: mismatch");
        $finish;
    end

endmodule
